>>> hw/rtl/c8ie_pkg.sv
`timescale 1ns / 1ps

package c8ie_pkg;

  localparam int MEM_BYTES   = 4096;
  localparam int MEM_AW      = 12;
  localparam int SCR_W       = 64;
  localparam int SCR_H       = 32;
  localparam int COL_AW      = 6;
  localparam int ROW_AW      = 5;
  localparam int STACK_DEPTH = 16;
  localparam int STK_AW      = 4;
  localparam int STK_CW      = 5;
  localparam int FONT_BYTES  = 80;

  localparam logic [11:0] FONT_BASE = 12'h050;
  localparam logic [11:0] PC_RESET  = 12'h200;
  localparam logic [15:0] OP_CLS    = 16'h00E0;
  localparam logic [15:0] OP_RET    = 16'h00EE;

  // Command codes of the input item.
  localparam logic [2:0] CMD_WRITE = 3'd0;
  localparam logic [2:0] CMD_READ  = 3'd1;
  localparam logic [2:0] CMD_PIXEL = 3'd2;
  localparam logic [2:0] CMD_REG   = 3'd3;
  localparam logic [2:0] CMD_STEP  = 3'd4;

  // Status codes of the result item.
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_UNK   = 2'd1;
  localparam logic [1:0] ST_UNDER = 2'd2;
  localparam logic [1:0] ST_OVER  = 2'd3;

  // Instruction classes (top nibble).
  localparam logic [3:0] OPC_SYS  = 4'h0;
  localparam logic [3:0] OPC_JP   = 4'h1;
  localparam logic [3:0] OPC_CALL = 4'h2;
  localparam logic [3:0] OPC_SEB  = 4'h3;
  localparam logic [3:0] OPC_SNEB = 4'h4;
  localparam logic [3:0] OPC_SER  = 4'h5;
  localparam logic [3:0] OPC_LD   = 4'h6;
  localparam logic [3:0] OPC_ADD  = 4'h7;
  localparam logic [3:0] OPC_ALU  = 4'h8;
  localparam logic [3:0] OPC_SNER = 4'h9;
  localparam logic [3:0] OPC_LDI  = 4'hA;
  localparam logic [3:0] OPC_JPV  = 4'hB;
  localparam logic [3:0] OPC_RND  = 4'hC;
  localparam logic [3:0] OPC_DRW  = 4'hD;

  // Arithmetic group sub-codes (low nibble).
  localparam logic [3:0] ALU_MOV = 4'h0;
  localparam logic [3:0] ALU_OR  = 4'h1;
  localparam logic [3:0] ALU_AND = 4'h2;
  localparam logic [3:0] ALU_XOR = 4'h3;
  localparam logic [3:0] ALU_ADD = 4'h4;
  localparam logic [3:0] ALU_SUB = 4'h5;
  localparam logic [3:0] ALU_SHR = 4'h6;
  localparam logic [3:0] ALU_SBN = 4'h7;
  localparam logic [3:0] ALU_SHL = 4'hE;

  localparam logic [7:0] FONT [FONT_BYTES] = '{
    8'hF0, 8'h90, 8'h90, 8'h90, 8'hF0, 8'h20, 8'h60, 8'h20, 8'h20, 8'h70,
    8'hF0, 8'h10, 8'hF0, 8'h80, 8'hF0, 8'hF0, 8'h10, 8'hF0, 8'h10, 8'hF0,
    8'h90, 8'h90, 8'hF0, 8'h10, 8'h10, 8'hF0, 8'h80, 8'hF0, 8'h10, 8'hF0,
    8'hF0, 8'h80, 8'hF0, 8'h90, 8'hF0, 8'hF0, 8'h10, 8'h20, 8'h40, 8'h40,
    8'hF0, 8'h90, 8'hF0, 8'h90, 8'hF0, 8'hF0, 8'h90, 8'hF0, 8'h10, 8'hF0,
    8'hF0, 8'h90, 8'hF0, 8'h90, 8'h90, 8'hE0, 8'h90, 8'hE0, 8'h90, 8'hE0,
    8'hF0, 8'h80, 8'h80, 8'h80, 8'hF0, 8'hE0, 8'h90, 8'h90, 8'h90, 8'hE0,
    8'hF0, 8'h80, 8'hF0, 8'h80, 8'hF0, 8'hF0, 8'h80, 8'hF0, 8'h80, 8'h80
  };

  typedef enum logic [4:0] {
    S_CLEAR, S_IDLE, S_RDMEM, S_RDPIX, S_RDREG,
    S_F0, S_F1, S_F2, S_RDX, S_RDY, S_GETY, S_EXEC,
    S_WRF, S_RET, S_DRD, S_DWR, S_RESP
  } state_t;

  typedef struct packed {
    logic       wr_x;
    logic       wr_f;
    logic       skip;
    logic       unknown;
    logic [7:0] val;
    logic       flag;
  } alu_res_t;

endpackage

>>> hw/rtl/c8ie_if.sv
`timescale 1ns / 1ps

interface c8ie_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  command;
  logic [11:0] mem_address;
  logic [7:0]  write_byte;
  logic [5:0]  pixel_column;
  logic [4:0]  pixel_row;
  logic [3:0]  register_select;
  logic [7:0]  random_byte;

  modport source(output valid, command, mem_address, write_byte, pixel_column,
                 pixel_row, register_select, random_byte, input ready);
  modport sink(input valid, command, mem_address, write_byte, pixel_column,
               pixel_row, register_select, random_byte, output ready);
endinterface

interface c8ie_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  read_value;
  logic [11:0] program_counter_out;
  logic [11:0] index_out;
  logic [15:0] executed_opcode;
  logic [1:0]  status;

  modport source(output valid, read_value, program_counter_out, index_out,
                 executed_opcode, status, input ready);
  modport sink(input valid, read_value, program_counter_out, index_out,
               executed_opcode, status, output ready);
endinterface

>>> hw/rtl/chip8_instruction_execute_unit.sv
`timescale 1ns / 1ps

// CHIP-8 interpreter core with its own memory, pixel plane and registers.
// One beat on in_ch carries a command: write or read a memory byte, read a
// pixel, read a data register, or step one instruction. Every accepted beat
// gives exactly one beat on out_ch with the read value, the program counter,
// the index register, the fetched opcode and a status code.
// Memory, register and pixel reads all go through arrays with one write
// port, one read port and registered read data, and one ALU serves the
// skip and register-writing instructions, so the sequencer walks each
// command through a chain of states, with a read and a write per drawn row.
// The row-at-a-time read-modify-write of the pixel plane sets the draw cost.
// in_ch.ready is high only while the sequencer is idle; the finished result
// sits in an output register, and the sequencer waits at its last step while
// the receiver stalls with a full output register.
// After reset the core sweeps every main memory address, loading the font
// and zeroing the rest; in_ch.ready stays low during that sweep. Pixel rows
// and data registers are cleared at once through per-entry valid bits.

module chip8_instruction_execute_unit (
  input  logic        clk,
  input  logic        rst_n,
  c8ie_in_if.sink     in_ch,
  c8ie_out_if.source  out_ch
);
  import c8ie_pkg::*;

  state_t state_r, state_nxt;

  // Main memory, pixel rows, data registers and return stack.
  logic [7:0]       mem [MEM_BYTES];
  logic [SCR_W-1:0] pix [SCR_H];
  logic [7:0]       vreg [16];
  logic [11:0]      stk [STACK_DEPTH];

  logic [7:0]       mem_q_r;
  logic [SCR_W-1:0] pix_q_r;
  logic             pix_qv_r;
  logic [SCR_H-1:0] pix_vld_r, pix_vld_nxt;
  logic [7:0]       v_q_r;
  logic             v_qv_r;
  logic [15:0]      v_vld_r, v_vld_nxt;
  logic [11:0]      stk_q_r;

  logic             mem_we;
  logic [11:0]      mem_waddr, mem_raddr;
  logic [7:0]       mem_wdata;
  logic             pix_we;
  logic [ROW_AW-1:0] pix_waddr, pix_raddr;
  logic [SCR_W-1:0] pix_wdata;
  logic             v_we;
  logic [3:0]       v_waddr, v_raddr;
  logic [7:0]       v_wdata;
  logic             stk_we;
  logic [STK_AW-1:0] stk_waddr, stk_raddr;

  logic [11:0] clr_cnt_r, clr_cnt_nxt;
  logic [2:0]  cmd_r, cmd_nxt;
  logic [11:0] addr_r, addr_nxt;
  logic [5:0]  col_r, col_nxt;
  logic [7:0]  rnd_r, rnd_nxt;
  logic [11:0] pc_r, pc_nxt;
  logic [11:0] idx_r, idx_nxt;
  logic [7:0]  hi_r, hi_nxt;
  logic [15:0] op_r, op_nxt;
  logic [7:0]  vx_r, vx_nxt;
  logic [7:0]  vy_r, vy_nxt;
  logic [STK_CW-1:0] stk_cnt_r, stk_cnt_nxt;
  logic [1:0]  status_r, status_nxt;
  logic [7:0]  value_r, value_nxt;
  logic        hit_r, hit_nxt;
  logic [3:0]  drow_r, drow_nxt;

  logic        out_valid_r, out_valid_nxt;
  logic [7:0]  o_val_r, o_val_nxt;
  logic [11:0] o_pc_r, o_pc_nxt;
  logic [11:0] o_idx_r, o_idx_nxt;
  logic [15:0] o_op_r, o_op_nxt;
  logic [1:0]  o_st_r, o_st_nxt;

  logic        in_fire, out_free;
  logic [7:0]  v_eff;
  logic [11:0] font_ofs;
  logic [4:0]  nrow;
  logic [5:0]  nrow_y;
  logic [SCR_W-1:0] spr_mask, row_cur;
  logic [11:0] pc_inc;
  alu_res_t    alu;

  c8ie_alu u_alu (
    .op  (op_r),
    .vx  (vx_r),
    .vy  (vy_r),
    .rnd (rnd_r),
    .res (alu)
  );

  assign in_fire   = in_ch.valid && in_ch.ready;
  assign out_free  = !out_valid_r || out_ch.ready;
  assign v_eff     = v_qv_r ? v_q_r : 8'd0;
  assign font_ofs  = clr_cnt_r - FONT_BASE;
  assign nrow      = {1'b0, drow_r} + 5'd1;
  assign nrow_y    = {1'b0, vy_r[ROW_AW-1:0]} + {1'b0, nrow};
  assign row_cur   = pix_qv_r ? pix_q_r : '0;
  assign spr_mask  = {mem_q_r, {(SCR_W-8){1'b0}}} >> vx_r[COL_AW-1:0];
  assign pc_inc    = pc_r + 12'd2;

  assign in_ch.ready                = (state_r == S_IDLE);
  assign out_ch.valid               = out_valid_r;
  assign out_ch.read_value          = o_val_r;
  assign out_ch.program_counter_out = o_pc_r;
  assign out_ch.index_out           = o_idx_r;
  assign out_ch.executed_opcode     = o_op_r;
  assign out_ch.status              = o_st_r;

  // Sequencer next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_CLEAR: if (clr_cnt_r == 12'hFFF) state_nxt = S_IDLE;
      S_IDLE: begin
        if (in_fire) begin
          case (in_ch.command)
            CMD_READ:  state_nxt = S_RDMEM;
            CMD_PIXEL: state_nxt = S_RDPIX;
            CMD_REG:   state_nxt = S_RDREG;
            CMD_STEP:  state_nxt = S_F0;
            default:   state_nxt = S_RESP;
          endcase
        end
      end
      S_RDMEM, S_RDPIX, S_RDREG: state_nxt = S_RESP;
      S_F0:   state_nxt = S_F1;
      S_F1:   state_nxt = S_F2;
      S_F2:   state_nxt = S_RDX;
      S_RDX:  state_nxt = S_RDY;
      S_RDY:  state_nxt = S_GETY;
      S_GETY: state_nxt = S_EXEC;
      S_EXEC: begin
        state_nxt = S_RESP;
        case (op_r[15:12])
          OPC_SYS: begin
            if (op_r == OP_RET && stk_cnt_r != '0) state_nxt = S_RET;
          end
          OPC_LD, OPC_ADD, OPC_ALU, OPC_RND: begin
            if (alu.wr_f) state_nxt = S_WRF;
          end
          OPC_DRW: state_nxt = (op_r[3:0] == 4'd0) ? S_WRF : S_DRD;
          default: state_nxt = S_RESP;
        endcase
      end
      S_WRF, S_RET: state_nxt = S_RESP;
      S_DRD: state_nxt = S_DWR;
      S_DWR: begin
        if (nrow < {1'b0, op_r[3:0]} && nrow_y < 6'(SCR_H)) state_nxt = S_DRD;
        else state_nxt = S_WRF;
      end
      S_RESP: if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // Datapath controls and register updates.
  always_comb begin
    mem_we      = 1'b0;
    mem_waddr   = in_ch.mem_address;
    mem_wdata   = in_ch.write_byte;
    mem_raddr   = pc_r;
    pix_we      = 1'b0;
    pix_waddr   = vy_r[ROW_AW-1:0] + ROW_AW'(drow_r);
    pix_wdata   = row_cur ^ spr_mask;
    pix_raddr   = vy_r[ROW_AW-1:0] + ROW_AW'(drow_r);
    v_we        = 1'b0;
    v_waddr     = op_r[11:8];
    v_wdata     = alu.val;
    v_raddr     = op_r[11:8];
    stk_we      = 1'b0;
    stk_waddr   = stk_cnt_r[STK_AW-1:0];
    stk_raddr   = STK_AW'(stk_cnt_r - 5'd1);

    clr_cnt_nxt = clr_cnt_r;
    cmd_nxt     = cmd_r;
    addr_nxt    = addr_r;
    col_nxt     = col_r;
    rnd_nxt     = rnd_r;
    pc_nxt      = pc_r;
    idx_nxt     = idx_r;
    hi_nxt      = hi_r;
    op_nxt      = op_r;
    vx_nxt      = vx_r;
    vy_nxt      = vy_r;
    stk_cnt_nxt = stk_cnt_r;
    status_nxt  = status_r;
    value_nxt   = value_r;
    hit_nxt     = hit_r;
    drow_nxt    = drow_r;
    pix_vld_nxt = pix_vld_r;
    v_vld_nxt   = v_vld_r;

    out_valid_nxt = out_valid_r && !out_ch.ready;
    o_val_nxt = o_val_r;
    o_pc_nxt  = o_pc_r;
    o_idx_nxt = o_idx_r;
    o_op_nxt  = o_op_r;
    o_st_nxt  = o_st_r;

    unique case (state_r)
      S_CLEAR: begin
        mem_we      = 1'b1;
        mem_waddr   = clr_cnt_r;
        mem_wdata   = (font_ofs < 12'(FONT_BYTES)) ? FONT[font_ofs[6:0]] : 8'd0;
        clr_cnt_nxt = clr_cnt_r + 12'd1;
      end
      S_IDLE: begin
        mem_raddr  = in_ch.mem_address;
        pix_raddr  = in_ch.pixel_row;
        v_raddr    = in_ch.register_select;
        cmd_nxt    = in_ch.command;
        addr_nxt   = in_ch.mem_address;
        col_nxt    = in_ch.pixel_column;
        rnd_nxt    = in_ch.random_byte;
        status_nxt = ST_OK;
        value_nxt  = 8'd0;
        op_nxt     = 16'd0;
        if (in_fire && in_ch.command == CMD_WRITE) mem_we = 1'b1;
      end
      S_RDMEM: value_nxt = mem_q_r;
      S_RDPIX: value_nxt = {7'd0, pix_qv_r & pix_q_r[~col_r]};
      S_RDREG: value_nxt = v_eff;
      S_F0: mem_raddr = pc_r;
      S_F1: begin
        hi_nxt    = mem_q_r;
        mem_raddr = pc_r + 12'd1;
      end
      S_F2: begin
        op_nxt = {hi_r, mem_q_r};
        pc_nxt = pc_inc;
      end
      S_RDX: v_raddr = op_r[11:8];
      S_RDY: begin
        vx_nxt  = v_eff;
        v_raddr = (op_r[15:12] == OPC_JPV) ? 4'd0 : op_r[7:4];
      end
      S_GETY: vy_nxt = v_eff;
      S_EXEC: begin
        hit_nxt  = alu.flag;
        drow_nxt = 4'd0;
        case (op_r[15:12])
          OPC_SYS: begin
            if (op_r == OP_CLS) begin
              pix_vld_nxt = '0;
            end else if (op_r == OP_RET) begin
              if (stk_cnt_r == '0) status_nxt = ST_UNDER;
              else stk_cnt_nxt = stk_cnt_r - 5'd1;
            end else begin
              status_nxt = ST_UNK;
            end
          end
          OPC_JP: pc_nxt = op_r[11:0];
          OPC_CALL: begin
            if (stk_cnt_r >= STK_CW'(STACK_DEPTH)) begin
              status_nxt = ST_OVER;
            end else begin
              stk_we      = 1'b1;
              stk_cnt_nxt = stk_cnt_r + 5'd1;
              pc_nxt      = op_r[11:0];
            end
          end
          OPC_SEB, OPC_SNEB, OPC_SER, OPC_SNER: if (alu.skip) pc_nxt = pc_inc;
          OPC_LD, OPC_ADD, OPC_ALU, OPC_RND: begin
            if (alu.unknown) begin
              status_nxt = ST_UNK;
            end else begin
              v_we      = 1'b1;
              v_vld_nxt = v_vld_r | (16'd1 << op_r[11:8]);
            end
          end
          OPC_LDI: idx_nxt = op_r[11:0];
          OPC_JPV: pc_nxt = op_r[11:0] + {4'd0, vy_r};
          OPC_DRW: hit_nxt = 1'b0;
          default: status_nxt = ST_UNK;
        endcase
      end
      S_RET: pc_nxt = stk_q_r;
      S_WRF: begin
        v_we      = 1'b1;
        v_waddr   = 4'hF;
        v_wdata   = {7'd0, hit_r};
        v_vld_nxt = v_vld_r | 16'h8000;
      end
      S_DRD: mem_raddr = idx_r + {8'd0, drow_r};
      S_DWR: begin
        pix_we      = 1'b1;
        pix_vld_nxt = pix_vld_r | (SCR_H'(1) << pix_waddr);
        hit_nxt     = hit_r | (|(row_cur & spr_mask));
        drow_nxt    = nrow[3:0];
      end
      S_RESP: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          o_val_nxt = value_r;
          o_pc_nxt  = pc_r;
          o_idx_nxt = idx_r;
          o_op_nxt  = op_r;
          o_st_nxt  = status_r;
        end
      end
      default: mem_we = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_cnt_r   <= '0;
      pc_r        <= PC_RESET;
      idx_r       <= '0;
      stk_cnt_r   <= '0;
      pix_vld_r   <= '0;
      v_vld_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      pc_r        <= pc_nxt;
      idx_r       <= idx_nxt;
      stk_cnt_r   <= stk_cnt_nxt;
      pix_vld_r   <= pix_vld_nxt;
      v_vld_r     <= v_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r    <= cmd_nxt;
    addr_r   <= addr_nxt;
    col_r    <= col_nxt;
    rnd_r    <= rnd_nxt;
    hi_r     <= hi_nxt;
    op_r     <= op_nxt;
    vx_r     <= vx_nxt;
    vy_r     <= vy_nxt;
    status_r <= status_nxt;
    value_r  <= value_nxt;
    hit_r    <= hit_nxt;
    drow_r   <= drow_nxt;
    o_val_r  <= o_val_nxt;
    o_pc_r   <= o_pc_nxt;
    o_idx_r  <= o_idx_nxt;
    o_op_r   <= o_op_nxt;
    o_st_r   <= o_st_nxt;
  end

  // Arrays: one write and one registered read each per cycle.
  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    mem_q_r <= mem[mem_raddr];
  end

  always_ff @(posedge clk) begin
    if (pix_we) pix[pix_waddr] <= pix_wdata;
    pix_q_r  <= pix[pix_raddr];
    pix_qv_r <= pix_vld_r[pix_raddr];
  end

  always_ff @(posedge clk) begin
    if (v_we) vreg[v_waddr] <= v_wdata;
    v_q_r  <= vreg[v_raddr];
    v_qv_r <= v_vld_r[v_raddr];
  end

  always_ff @(posedge clk) begin
    if (stk_we) stk[stk_waddr] <= pc_r;
    stk_q_r <= stk[stk_raddr];
  end

`ifndef ASSERT_OFF
  a_stk_bound: assert property (@(posedge clk) disable iff (!rst_n)
    stk_cnt_r <= STK_CW'(STACK_DEPTH))
    else $error("return stack count beyond depth");

  a_step_fetch: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_ch.command == CMD_STEP) |=> (state_r == S_F0))
    else $error("step command did not start a fetch");

  a_draw_row: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DWR) |->
      (({1'b0, vy_r[ROW_AW-1:0]} + {2'b0, drow_r}) < 6'(SCR_H)))
    else $error("sprite row drawn below the screen");

  a_resp_load: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RESP && out_free) |=> out_valid_r)
    else $error("result not loaded into output register");
`endif

endmodule

>>> hw/rtl/c8ie_alu.sv
`timescale 1ns / 1ps

module c8ie_alu (
  input  logic [15:0]        op,
  input  logic [7:0]         vx,
  input  logic [7:0]         vy,
  input  logic [7:0]         rnd,
  output c8ie_pkg::alu_res_t res
);
  import c8ie_pkg::*;

  logic [7:0] nn;
  logic [8:0] sum;

  assign nn  = op[7:0];
  assign sum = {1'b0, vx} + {1'b0, vy};

  always_comb begin
    res = '0;
    unique case (op[15:12])
      OPC_SEB:  res.skip = (vx == nn);
      OPC_SNEB: res.skip = (vx != nn);
      OPC_SER:  res.skip = (vx == vy);
      OPC_SNER: res.skip = (vx != vy);
      OPC_LD: begin
        res.wr_x = 1'b1;
        res.val  = nn;
      end
      OPC_ADD: begin
        res.wr_x = 1'b1;
        res.val  = vx + nn;
      end
      OPC_RND: begin
        res.wr_x = 1'b1;
        res.val  = rnd & nn;
      end
      OPC_ALU: begin
        res.wr_x = 1'b1;
        unique case (op[3:0])
          ALU_MOV: res.val = vy;
          ALU_OR:  res.val = vx | vy;
          ALU_AND: res.val = vx & vy;
          ALU_XOR: res.val = vx ^ vy;
          ALU_ADD: begin
            res.val  = sum[7:0];
            res.flag = sum[8];
            res.wr_f = 1'b1;
          end
          ALU_SUB: begin
            res.val  = vx - vy;
            res.flag = (vx >= vy);
            res.wr_f = 1'b1;
          end
          ALU_SBN: begin
            res.val  = vy - vx;
            res.flag = (vy >= vx);
            res.wr_f = 1'b1;
          end
          ALU_SHR: begin
            res.val  = {1'b0, vy[7:1]};
            res.flag = vy[0];
            res.wr_f = 1'b1;
          end
          ALU_SHL: begin
            res.val  = {vy[6:0], 1'b0};
            res.flag = vy[7];
            res.wr_f = 1'b1;
          end
          default: begin
            res.wr_x    = 1'b0;
            res.unknown = 1'b1;
          end
        endcase
      end
      default: res = '0;
    endcase
  end

endmodule
